// File: hw/rtl/smp_pkg.sv
// ----------------------------------------------------------------------------
// smp_pkg
// Shared types and constants of the synchronized axis move planner.
// ----------------------------------------------------------------------------
package smp_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_MAX_SPEED   = 2'd0;
	localparam logic [1:0] REG_MAX_ACCEL   = 2'd1;
	localparam logic [1:0] REG_SPEED_SCALE = 2'd2;

	localparam logic [15:0] MAX_SPEED_RST   = 16'd1000;
	localparam logic [15:0] MAX_ACCEL_RST   = 16'd500;
	localparam logic [15:0] SPEED_SCALE_RST = 16'd256;

	localparam int DIV_N_W = 64;
	localparam int DIV_D_W = 32;
	localparam int SQRT_W  = 48;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_T_MUL,
		ST_T_DIV,
		ST_T_DWAIT,
		ST_T_SQRT,
		ST_L_MUL1,
		ST_L_MUL2,
		ST_L_DIV,
		ST_L_DWAIT,
		ST_OUT_LOAD,
		ST_OUT_WAIT
	} smp_state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic clear_group;
		logic time_mul;
		logic time_div_start;
		logic sqrt_start;
		logic time_load_div;
		logic time_load_sqrt;
		logic lim_mul1;
		logic lim_mul2;
		logic lim_div_start;
		logic lim_load;
		logic out_load;
		logic axis_next;
	} smp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic close_ok;
		logic tri_prof;
		logic div_done;
		logic sqrt_done;
		logic dmax_zero;
		logic sel_accel;
		logic axis_last;
		logic out_taken;
	} smp_stat_t;

endpackage

// File: hw/rtl/smp_div.sv
// ----------------------------------------------------------------------------
// smp_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module smp_div import smp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIV_N_W-1:0]   dividend,
	input  logic [DIV_D_W-1:0]   divisor,
	output logic                 done,
	output logic [DIV_N_W-1:0]   quotient
);

	localparam int CNT_W = $clog2(DIV_N_W + 1);

	logic [DIV_D_W:0]   rem_q;
	logic [DIV_N_W-1:0] quo_q;
	logic [DIV_D_W-1:0] dvs_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [DIV_D_W:0]   rem_sh;
	logic               ge;

	// one shift and subtract step
	always_comb begin
		rem_sh = {rem_q[DIV_D_W-1:0], quo_q[DIV_N_W-1]};
		ge     = (rem_sh >= {1'b0, dvs_q});
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_N_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// data
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
			quo_q <= {quo_q[DIV_N_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: hw/rtl/smp_sqrt.sv
// ----------------------------------------------------------------------------
// smp_sqrt
// Digit-by-digit integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module smp_sqrt import smp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [SQRT_W-1:0]     radicand,
	output logic                  done,
	output logic [SQRT_W/2-1:0]   root
);

	localparam int RT_W  = SQRT_W / 2;
	localparam int REM_W = RT_W + 3;
	localparam int CNT_W = $clog2(RT_W + 1);

	logic [REM_W-1:0]  rem_q;
	logic [RT_W-1:0]   root_q;
	logic [SQRT_W-1:0] x_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [REM_W-1:0]  rem_sh;
	logic [REM_W-1:0]  trial;
	logic              ge;

	// trial subtract of the next digit
	always_comb begin
		rem_sh = {rem_q[REM_W-3:0], x_q[SQRT_W-1 -: 2]};
		trial  = {1'b0, root_q, 2'b01};
		ge     = (rem_sh >= trial);
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(RT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// data
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			root_q <= '0;
			x_q    <= radicand;
		end else if (busy_q) begin
			rem_q  <= ge ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[RT_W-2:0], ge};
			x_q    <= {x_q[SQRT_W-3:0], 2'b00};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// File: hw/rtl/smp_datapath.sv
// ----------------------------------------------------------------------------
// smp_datapath
// Distance store, configuration registers, multipliers, shared divider and
// square root, and the result register.
// ----------------------------------------------------------------------------
module smp_datapath import smp_pkg::*; #(
	parameter int AXES = 6
) (
	input  logic               clk,
	input  logic               arst_n,
	input  smp_cmd_t           cmd,
	output smp_stat_t          stat,
	input  logic signed [23:0] current_position,
	input  logic signed [23:0] target_position,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               out_stall,
	output logic               out_valid,
	output logic [2:0]         axis_index,
	output logic [15:0]        speed_limit,
	output logic [15:0]        accel_limit,
	output logic [31:0]        move_time,
	output logic               last_result
);

	logic [15:0] max_speed_q, max_accel_q, speed_scale_q;
	logic [23:0] dist_q [8];
	logic [23:0] dmax_q;
	logic [3:0]  count_q;
	logic [2:0]  axis_q;
	logic        sel_q;
	logic        tri_q;
	logic [31:0] vv_q, va_q;
	logic [39:0] da_q;
	logic [39:0] p1_q;
	logic [55:0] num_q;
	logic [31:0] time_q;
	logic [15:0] spd_q, acc_q;
	logic        out_valid_q;
	logic [2:0]  out_axis_q;
	logic [15:0] out_spd_q, out_acc_q;
	logic [31:0] out_time_q;
	logic        out_last_q;

	logic signed [24:0] diff;
	logic [24:0]        diff_abs;
	logic [23:0]        item_dist;
	logic [15:0]        v_eff, a_eff, lim_max;
	logic [40:0]        trap_sum;
	logic               tri_now;
	logic               div_start, div_done, sqrt_done;
	logic [DIV_N_W-1:0] div_n, div_q;
	logic [DIV_D_W-1:0] div_d;
	logic [SQRT_W/2-1:0] sqrt_r;
	logic [15:0]        lim_val;

	// absolute distance of the incoming item
	always_comb begin
		diff      = 25'(target_position) - 25'(current_position);
		diff_abs  = diff[24] ? 25'(-diff) : diff;
		item_dist = diff_abs[23:0];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q   <= MAX_SPEED_RST;
			max_accel_q   <= MAX_ACCEL_RST;
			speed_scale_q <= SPEED_SCALE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_SPEED:   max_speed_q   <= cfg_data;
				REG_MAX_ACCEL:   max_accel_q   <= cfg_data;
				REG_SPEED_SCALE: speed_scale_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// group bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			dmax_q  <= '0;
			axis_q  <= '0;
			sel_q   <= 1'b0;
		end else begin
			if (cmd.clear_group) begin
				count_q <= '0;
				dmax_q  <= '0;
				axis_q  <= '0;
				sel_q   <= 1'b0;
			end else if (cmd.accept && (count_q < 4'(AXES))) begin
				count_q <= count_q + 1'b1;
				if (item_dist > dmax_q)
					dmax_q <= item_dist;
			end
			if (cmd.axis_next)
				axis_q <= axis_q + 1'b1;
			if (cmd.lim_load)
				sel_q <= ~sel_q;
		end
	end

	// distance store
	always_ff @(posedge clk) begin
		if (cmd.accept && (count_q < 4'(AXES)))
			dist_q[count_q[2:0]] <= item_dist;
	end

	// profile products, zero speed or accel counts as one
	always_comb begin
		v_eff    = (max_speed_q == '0) ? 16'd1 : max_speed_q;
		a_eff    = (max_accel_q == '0) ? 16'd1 : max_accel_q;
		trap_sum = 41'(da_q) + 41'(vv_q);
		tri_now  = (40'(vv_q) >= da_q);
		lim_max  = sel_q ? max_accel_q : max_speed_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.time_mul) begin
			vv_q <= 32'(v_eff) * 32'(v_eff);
			va_q <= 32'(v_eff) * 32'(a_eff);
			da_q <= 40'(dmax_q) * 40'(a_eff);
		end
		if (cmd.time_div_start)
			tri_q <= tri_now;
		if (cmd.lim_mul1)
			p1_q <= 40'(dist_q[axis_q]) * 40'(lim_max);
		if (cmd.lim_mul2)
			num_q <= 56'(p1_q) * 56'(speed_scale_q);
	end

	// divider operands
	always_comb begin
		div_start = cmd.time_div_start | cmd.lim_div_start;
		if (cmd.time_div_start) begin
			if (tri_now) begin
				div_n = DIV_N_W'({dmax_q, 22'd0});
				div_d = DIV_D_W'(a_eff);
			end else begin
				div_n = DIV_N_W'({trap_sum, 10'd0});
				div_d = va_q;
			end
		end else begin
			div_n = DIV_N_W'(num_q);
			div_d = {dmax_q, 8'd0};
		end
	end

	smp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_n),
		.divisor  (div_d),
		.done     (div_done),
		.quotient (div_q)
	);

	smp_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.sqrt_start),
		.radicand (div_q[SQRT_W-1:0]),
		.done     (sqrt_done),
		.root     (sqrt_r)
	);

	// saturated limit
	always_comb begin
		if (dmax_q == '0)
			lim_val = lim_max;
		else if (div_q[DIV_N_W-1:16] != '0)
			lim_val = 16'hFFFF;
		else
			lim_val = div_q[15:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.time_load_div)
			time_q <= (div_q[DIV_N_W-1:32] != '0) ? 32'hFFFF_FFFF : div_q[31:0];
		if (cmd.time_load_sqrt)
			time_q <= 32'(sqrt_r);
		if (cmd.lim_load) begin
			if (sel_q)
				acc_q <= lim_val;
			else
				spd_q <= lim_val;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (out_valid_q && !out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_axis_q <= axis_q;
			out_spd_q  <= spd_q;
			out_acc_q  <= acc_q;
			out_time_q <= time_q;
			out_last_q <= (axis_q == 3'(AXES - 1));
		end
	end

	// status
	always_comb begin
		stat.close_ok  = (count_q >= 4'(AXES - 1));
		stat.tri_prof  = tri_q;
		stat.div_done  = div_done;
		stat.sqrt_done = sqrt_done;
		stat.dmax_zero = (dmax_q == '0);
		stat.sel_accel = sel_q;
		stat.axis_last = (axis_q == 3'(AXES - 1));
		stat.out_taken = out_valid_q & ~out_stall;
	end

	assign out_valid   = out_valid_q;
	assign axis_index  = out_axis_q;
	assign speed_limit = out_spd_q;
	assign accel_limit = out_acc_q;
	assign move_time   = out_time_q;
	assign last_result = out_last_q;

endmodule

// File: hw/rtl/smp_ctrl.sv
// ----------------------------------------------------------------------------
// smp_ctrl
// Sequencer: item intake, move time, per-axis limits and result handoff.
// ----------------------------------------------------------------------------
module smp_ctrl import smp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      last_axis,
	output logic      in_stall,
	input  smp_stat_t stat,
	output smp_cmd_t  cmd
);

	smp_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && last_axis && stat.close_ok)
					state_d = ST_T_MUL;
			end
			ST_T_MUL:   state_d = ST_T_DIV;
			ST_T_DIV:   state_d = ST_T_DWAIT;
			ST_T_DWAIT: begin
				if (stat.div_done)
					state_d = stat.tri_prof ? ST_T_SQRT : ST_L_MUL1;
			end
			ST_T_SQRT: begin
				if (stat.sqrt_done)
					state_d = ST_L_MUL1;
			end
			ST_L_MUL1:  state_d = ST_L_MUL2;
			ST_L_MUL2:  state_d = ST_L_DIV;
			ST_L_DIV: begin
				if (stat.dmax_zero)
					state_d = stat.sel_accel ? ST_OUT_LOAD : ST_L_MUL1;
				else
					state_d = ST_L_DWAIT;
			end
			ST_L_DWAIT: begin
				if (stat.div_done)
					state_d = stat.sel_accel ? ST_OUT_LOAD : ST_L_MUL1;
			end
			ST_OUT_LOAD: state_d = ST_OUT_WAIT;
			ST_OUT_WAIT: begin
				if (stat.out_taken)
					state_d = stat.axis_last ? ST_IDLE : ST_L_MUL1;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
				if (in_valid && last_axis && !stat.close_ok)
					cmd.clear_group = 1'b1;
			end
			ST_T_MUL: cmd.time_mul = 1'b1;
			ST_T_DIV: cmd.time_div_start = 1'b1;
			ST_T_DWAIT: begin
				if (stat.div_done) begin
					cmd.sqrt_start    = stat.tri_prof;
					cmd.time_load_div = ~stat.tri_prof;
				end
			end
			ST_T_SQRT: cmd.time_load_sqrt = stat.sqrt_done;
			ST_L_MUL1: cmd.lim_mul1 = 1'b1;
			ST_L_MUL2: cmd.lim_mul2 = 1'b1;
			ST_L_DIV: begin
				cmd.lim_load      = stat.dmax_zero;
				cmd.lim_div_start = ~stat.dmax_zero;
			end
			ST_L_DWAIT: cmd.lim_load = stat.div_done;
			ST_OUT_LOAD: cmd.out_load = 1'b1;
			ST_OUT_WAIT: begin
				if (stat.out_taken) begin
					cmd.clear_group = stat.axis_last;
					cmd.axis_next   = ~stat.axis_last;
				end
			end
			default: ;
		endcase
	end

endmodule

// File: hw/rtl/synchronized_axis_move_planner_unit.sv
// Sequence: after the closing item the move time takes one 64-step divide (trapezoid)
// or a divide plus a 24-step square root (triangle); each axis result then takes two
// 64-step divides on the shared divider if the largest distance is nonzero, plus any
// output stall. Items are taken one per cycle while idle; none while a move is planned
// or its results are out.
// Reset (arst_n low, asynchronous) restores default registers and empties the group.
// ----------------------------------------------------------------------------
// synchronized_axis_move_planner_unit
// Multi-axis synchronized trapezoidal or triangular move planner: per-axis limits and move time.
// ----------------------------------------------------------------------------
module synchronized_axis_move_planner_unit import smp_pkg::*; #(
	parameter int AXES = 6
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [23:0] current_position,
	input  logic signed [23:0] target_position,
	input  logic               last_axis,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         axis_index,
	output logic [15:0]        speed_limit,
	output logic [15:0]        accel_limit,
	output logic [31:0]        move_time,
	output logic               last_result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	smp_cmd_t  cmd;
	smp_stat_t stat;

	// registers always take a write
	assign cfg_ready = 1'b1;

	smp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last_axis (last_axis),
		.in_stall  (in_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	smp_datapath #(
		.AXES (AXES)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.current_position (current_position),
		.target_position  (target_position),
		.cfg_we           (cfg_valid & cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.out_stall        (out_stall),
		.out_valid        (out_valid),
		.axis_index       (axis_index),
		.speed_limit      (speed_limit),
		.accel_limit      (accel_limit),
		.move_time        (move_time),
		.last_result      (last_result)
	);

endmodule

// File: tb/sv/smp_checker.sv
// ----------------------------------------------------------------------------
// smp_checker
// Watches the item, result and register channels of the move planner, works
// out the expected per-axis limits and move time of every full closed group, and
// compares each accepted result with the oldest expected one.
// ----------------------------------------------------------------------------
module smp_checker import smp_pkg::*; #(
	parameter int AXES = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [23:0] current_position,
	input  logic [23:0] target_position,
	input  logic        last_axis,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [2:0]  axis_index,
	input  logic [15:0] speed_limit,
	input  logic [15:0] accel_limit,
	input  logic [31:0] move_time,
	input  logic        last_result,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          fail_count,
	output int          pending,
	output int          checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [2:0]  ax;
		logic [15:0] spd;
		logic [15:0] acc;
		logic [31:0] mt;
		logic        lst;
	} axis_plan_t;

	axis_plan_t  plan_q[$];
	logic [15:0] top_speed, top_accel, scale;
	logic [23:0] dist_mem[8];
	logic [23:0] dist_max;
	int          count;

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x)
			b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// limit proportional to the axis share of the largest distance
	function automatic logic [15:0] share_limit(logic [23:0] d, logic [23:0] dm,
			logic [15:0] lim);
		longint unsigned q;
		if (dm == 0)
			return lim;
		q = (longint'(d) * lim * scale) / (longint'(dm) * 256);
		return (q > 65535) ? 16'hFFFF : q[15:0];
	endfunction

	// triangle or trapezoid move time in 1/1024 s
	function automatic logic [31:0] profile_ticks(logic [23:0] span);
		longint unsigned v, a, d, t;
		v = (top_speed == 0) ? 1 : top_speed;
		a = (top_accel == 0) ? 1 : top_accel;
		d = span;
		if (v * v >= d * a)
			t = int_sqrt((64'd4194304 * d) / a);
		else
			t = (64'd1024 * (d * a + v * v)) / (v * a);
		return (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
	endfunction

	assign pending = plan_q.size();

	always @(posedge clk or negedge arst_n) begin
		logic [23:0]     d;
		longint          diff;
		axis_plan_t      p;
		logic [31:0]     mt;
		if (!arst_n) begin
			top_speed  <= MAX_SPEED_RST;
			top_accel  <= MAX_ACCEL_RST;
			scale      <= SPEED_SCALE_RST;
			dist_max   = '0;
			count      = 0;
			fail_count <= 0;
			checked    <= 0;
			plan_q.delete();
		end else begin
			// register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MAX_SPEED:   top_speed <= cfg_data;
					REG_MAX_ACCEL:   top_accel <= cfg_data;
					REG_SPEED_SCALE: scale     <= cfg_data;
					default: ;
				endcase
			end
			// compare an accepted result with the oldest expected one
			if (out_valid && !out_stall) begin
				checked <= checked + 1;
				if (plan_q.size() == 0) begin
					$display("%0t: unexpected result axis %0d", $time, axis_index);
					fail_count <= fail_count + 1;
				end else begin
					p = plan_q.pop_front();
					if (axis_index !== p.ax || speed_limit !== p.spd ||
							accel_limit !== p.acc || move_time !== p.mt ||
							last_result !== p.lst) begin
						$display("%0t: mismatch expected ax=%0d spd=%0d acc=%0d t=%0d last=%0d",
							$time, p.ax, p.spd, p.acc, p.mt, p.lst);
						$display("%0t:          actual   ax=%0d spd=%0d acc=%0d t=%0d last=%0d",
							$time, axis_index, speed_limit, accel_limit, move_time,
							last_result);
						fail_count <= fail_count + 1;
					end
				end
			end
			// accepted axis item
			if (in_valid && !in_stall) begin
				diff = longint'($signed(target_position)) - longint'($signed(current_position));
				if (diff < 0)
					diff = -diff;
				d = diff[23:0];
				if (count < AXES) begin
					dist_mem[count] = d;
					if (d > dist_max)
						dist_max = d;
					count++;
				end
				if (last_axis) begin
					if (count >= AXES) begin
						mt = profile_ticks(dist_max);
						for (int i = 0; i < AXES; i++) begin
							p.ax  = i[2:0];
							p.spd = share_limit(dist_mem[i], dist_max, top_speed);
							p.acc = share_limit(dist_mem[i], dist_max, top_accel);
							p.mt  = mt;
							p.lst = (i == AXES - 1);
							plan_q.insert(plan_q.size(), p);
						end
					end
					count = 0;
					dist_max = '0;
				end
			end
		end
	end

endmodule

// File: tb/sv/tb_synchronized_axis_move_planner_unit.sv
// ----------------------------------------------------------------------------
// tb_synchronized_axis_move_planner_unit
// Drives axis items, register writes and result back-pressure into the move
// planner with random idling; the checker beside the block judges the results.
// ----------------------------------------------------------------------------
module tb_synchronized_axis_move_planner_unit import smp_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int AXES      = 6;
	localparam int SETTLE    = 1500;
	localparam int MAX_CYCLE = 800000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0, in_stall;
	logic [23:0] current_position = '0, target_position = '0;
	logic        last_axis = 0;
	logic        out_valid, out_stall = 0;
	logic [2:0]  axis_index;
	logic [15:0] speed_limit, accel_limit;
	logic [31:0] move_time;
	logic        last_result;
	logic        cfg_valid = 0, cfg_ready;
	logic [1:0]  cfg_index = REG_MAX_SPEED;
	logic [15:0] cfg_data = '0;
	int          fail_count, pending, checked;
	int          cycles = 0, items = 0, groups = 0;
	bit          calm = 0;

	synchronized_axis_move_planner_unit #(.AXES(AXES)) dut (.*);

	smp_checker #(.AXES(AXES)) chk (.*);

	always #5 clk = ~clk;

	// result back-pressure
	always @(posedge clk) begin
		out_stall <= !calm && ($urandom_range(0, 99) < 21);
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > MAX_CYCLE) begin
			$display("timeout after %0d cycles", cycles);
			$display("== FAIL ==");
			$finish;
		end
	end

	// valid stays up between back-to-back items unless a random idle or drain lowers it
	task automatic send_item(logic [23:0] cur, logic [23:0] tgt, logic lst);
		if (!calm && $urandom_range(0, 99) < 21) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid         <= 1;
		current_position <= cur;
		target_position  <= tgt;
		last_axis        <= lst;
		do @(posedge clk); while (in_stall);
		items++;
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_regs(logic [15:0] v, logic [15:0] a, logic [15:0] s);
		drain();
		write_reg(REG_MAX_SPEED, v);
		write_reg(REG_MAX_ACCEL, a);
		write_reg(REG_SPEED_SCALE, s);
		cfg_valid <= 0;
	endtask

	// random axis endpoints: full range, short moves or standing still
	task automatic axis_move(logic lst);
		logic [23:0] cur, tgt;
		cur = 24'($urandom());
		case ($urandom_range(0, 3))
			0: tgt = 24'($urandom());
			1: tgt = cur + 24'($signed($urandom_range(0, 2000)) - 1000);
			2: tgt = cur + 24'($signed($urandom_range(0, 200000)) - 100000);
			default: tgt = cur;
		endcase
		send_item(cur, tgt, lst);
	endtask

	task automatic move_group(int n, bit close);
		for (int k = 0; k < n; k++)
			axis_move(close && (k == n - 1));
		groups++;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extreme distances in both directions, zero and one step
		send_item(24'h800000, 24'h7FFFFF, 0);
		send_item(24'h7FFFFF, 24'h800000, 0);
		send_item(24'h000000, 24'h000000, 0);
		send_item(24'h7FFFFF, 24'h7FFFFF, 0);
		send_item(24'hFFFFFF, 24'h000000, 0);
		send_item(24'h123456, 24'hEDCBA9, 1);
		// zero largest distance
		for (int k = 0; k < AXES; k++)
			send_item(24'h5A5A5A, 24'h5A5A5A, k == AXES - 1);
		// short group is dropped
		move_group(3, 1);
		// long group, extra items ignored
		move_group(AXES + 2, 1);

		// random phases over several register settings
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				1: set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
				2: set_regs(16'd1, 16'd1, 16'd0);
				3: set_regs(16'd0, 16'd0, 16'd256);
				4: set_regs(16'hFFFF, 16'd1, 16'hFFFF);
				5: set_regs(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
					16'($urandom_range(0, 1024)));
				default: ;
			endcase
			calm = (ph == 2);
			for (int start = items; items - start < 55; ) begin
				case ($urandom_range(0, 9))
					0: move_group($urandom_range(1, AXES - 1), 1);
					1: move_group($urandom_range(AXES + 1, AXES + 3), 1);
					2: begin
						axis_move($urandom_range(0, 1));
						groups++;
					end
					default: move_group(AXES, 1);
				endcase
			end
		end
		calm = 0;

		drain();
		$display("%0d axis items in %0d groups, %0d results checked, 6 register settings",
			items, groups, checked);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
